// ----- hw/rtl/stcp_pkg.sv -----
// stcp_pkg: shared types, constants and column lookup for the set-time command parser.
// No dependencies.
`default_nettype none
package stcp_pkg;

  localparam int unsigned LineLen = 23;
  localparam logic [4:0] LastCol = 5'(LineLen - 1);

  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChNone  = 8'h00;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFormat   = 2'd1;
  localparam logic [1:0] StatusRange    = 2'd2;

  localparam logic [6:0] MaxHour   = 7'd23;
  localparam logic [6:0] MaxMinSec = 7'd59;
  localparam logic [6:0] MaxDate   = 7'd31;
  localparam logic [6:0] MaxMonth  = 7'd12;

  // where the two-digit value of a units column is stored
  localparam logic [2:0] DestNone   = 3'd0;
  localparam logic [2:0] DestHour   = 3'd1;
  localparam logic [2:0] DestMinute = 3'd2;
  localparam logic [2:0] DestSecond = 3'd3;
  localparam logic [2:0] DestDate   = 3'd4;
  localparam logic [2:0] DestMonth  = 3'd5;
  localparam logic [2:0] DestYear   = 3'd6;

  typedef struct packed {
    logic       line_end;   // CR or LF
    logic       last;       // final column of the line
    logic       bad;        // character does not fit its column
    logic       load_tens;  // tens digit column
    logic [3:0] digit;      // digit value, zero if not a digit
    logic [2:0] dest;       // accumulator written on a units column
  } dec_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [6:0] year_two_digit;
  } result_t;

  // fixed character of a column, ChNone for a digit column
  function automatic logic [7:0] fixed_char(input logic [4:0] col);
    logic [7:0] ch;
    case (col)
      5'd0:           ch = ChS;
      5'd1:           ch = ChE;
      5'd2:           ch = ChT;
      5'd3, 5'd12:    ch = ChSpace;
      5'd6, 5'd9:     ch = ChColon;
      5'd15, 5'd18:   ch = ChSlash;
      default:        ch = ChNone;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] dest_of(input logic [4:0] col);
    logic [2:0] d;
    case (col)
      5'd5:    d = DestHour;
      5'd8:    d = DestMinute;
      5'd11:   d = DestSecond;
      5'd14:   d = DestDate;
      5'd17:   d = DestMonth;
      5'd22:   d = DestYear;
      default: d = DestNone;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/stcp_decode.sv -----
// stcp_decode: classifies one character against the current column.
// Depends on stcp_pkg.
`default_nettype none
module stcp_decode (
  input  wire logic [4:0]  position,
  input  wire logic [7:0]  char_in,
  output stcp_pkg::dec_t   dec
);
  import stcp_pkg::*;

  logic [4:0] col;
  logic [7:0] want;
  logic       is_dig;
  logic [7:0] diff;

  always_comb begin
    col    = (position > LastCol) ? LastCol : position;
    want   = fixed_char(col);
    is_dig = (char_in >= ChZero) && (char_in <= ChNine);
    diff   = char_in - ChZero;

    dec.line_end  = (char_in == ChCr) || (char_in == ChLf);
    dec.last      = (col == LastCol);
    dec.digit     = is_dig ? diff[3:0] : 4'd0;
    dec.bad       = (want != ChNone) ? (char_in != want) : !is_dig;
    dec.dest      = (want != ChNone) ? DestNone : dest_of(col);
    dec.load_tens = 1'b0;
    case (col)
      5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd21: dec.load_tens = 1'b1;
      default: dec.load_tens = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/stcp_core.sv -----
// stcp_core: line state (column, error flag, accumulators) and result forming.
// Depends on stcp_pkg.
`default_nettype none
module stcp_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire stcp_pkg::dec_t dec,
  output logic [4:0]       position,
  output logic             emit,
  output stcp_pkg::result_t result
);
  import stcp_pkg::*;

  logic       format_bad, format_bad_next;
  logic [3:0] tens_digit, tens_digit_next;
  logic [6:0] hour_acc, minute_acc, second_acc, date_acc, month_acc, year_acc;
  logic [6:0] hour_next, minute_next, second_next, date_next, month_next, year_next;
  logic [6:0] val;
  logic       out_of_range;

  always_comb begin
    // tens*10 + units, at most 99
    val = ({3'd0, tens_digit} << 3) + ({3'd0, tens_digit} << 1) + {3'd0, dec.digit};

    format_bad_next = format_bad | dec.bad;
    tens_digit_next = dec.load_tens ? dec.digit : tens_digit;
    hour_next   = (dec.dest == DestHour)   ? val : hour_acc;
    minute_next = (dec.dest == DestMinute) ? val : minute_acc;
    second_next = (dec.dest == DestSecond) ? val : second_acc;
    date_next   = (dec.dest == DestDate)   ? val : date_acc;
    month_next  = (dec.dest == DestMonth)  ? val : month_acc;
    year_next   = (dec.dest == DestYear)   ? val : year_acc;

    out_of_range = (hour_next > MaxHour) || (minute_next > MaxMinSec) ||
                   (second_next > MaxMinSec) || (date_next == 7'd0) ||
                   (date_next > MaxDate) || (month_next == 7'd0) ||
                   (month_next > MaxMonth);

    emit   = dec.line_end || dec.last;
    result = '0;
    if (dec.line_end || format_bad_next) begin
      result.status = StatusFormat;
    end else if (out_of_range) begin
      result.status = StatusRange;
    end else begin
      result.status         = StatusOk;
      result.hour           = hour_next[4:0];
      result.minute         = minute_next[5:0];
      result.second         = second_next[5:0];
      result.day_of_month   = date_next[4:0];
      result.month          = month_next[3:0];
      result.year_two_digit = year_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && emit)) begin
      position   <= '0;
      format_bad <= 1'b0;
      tens_digit <= '0;
      hour_acc   <= '0;
      minute_acc <= '0;
      second_acc <= '0;
      date_acc   <= '0;
      month_acc  <= '0;
      year_acc   <= '0;
    end else if (step) begin
      position   <= position + 5'd1;
      format_bad <= format_bad_next;
      tens_digit <= tens_digit_next;
      hour_acc   <= hour_next;
      minute_acc <= minute_next;
      second_acc <= second_next;
      date_acc   <= date_next;
      month_acc  <= month_next;
      year_acc   <= year_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/set_time_command_parser_top.sv -----
// set_time_command_parser_top: parses "SET HH:MM:SS DD/MM/YYYY" one character at a time.
// Depends on stcp_pkg, stcp_decode, stcp_core.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------------
//   in      | in_valid / in_ready  | char_in[7:0]
//   out     | out_valid / out_ready| status, hour, minute, second, day_of_month,
//           |                      | month, year_two_digit
//
// One character per clock sustained, unless a line-ending character waits. An accepted
// character is held in the input register; the decode and state update between it
// and the result register is a single pass, with no further register between them.
// Characters that end no line leave nothing on the output side and never stall.
// A character that ends a line (23rd column, CR or LF) waits in the input register
// only while the result register is full and not being drained.
// rst (synchronous) empties both registers and returns the parser to column 0.
`default_nettype none
module set_time_command_parser_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status,
  output logic [4:0]      hour,
  output logic [5:0]      minute,
  output logic [5:0]      second,
  output logic [4:0]      day_of_month,
  output logic [3:0]      month,
  output logic [6:0]      year_two_digit
);
  import stcp_pkg::*;

  logic       char_valid;
  logic [7:0] char_q;
  logic [4:0] position;
  dec_t       dec;
  logic       emit;
  result_t    result;
  result_t    result_q;
  logic       out_free;
  logic       step;

  // result slot can take a new transaction this cycle
  assign out_free = !out_valid || out_ready;
  // held character is processed unless it needs the result slot and that is full
  assign step     = char_valid && (!emit || out_free);
  assign in_ready = !char_valid || step;

  stcp_decode u_decode (
    .position (position),
    .char_in  (char_q),
    .dec      (dec)
  );

  stcp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .dec      (dec),
    .position (position),
    .emit     (emit),
    .result   (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (in_ready) begin
      char_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_q <= char_in;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && emit) begin
      result_q <= result;
    end
  end

  assign status         = result_q.status;
  assign hour           = result_q.hour;
  assign minute         = result_q.minute;
  assign second         = result_q.second;
  assign day_of_month   = result_q.day_of_month;
  assign month          = result_q.month;
  assign year_two_digit = result_q.year_two_digit;

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// tb: self-checking testbench for set_time_command_parser_top.
// Sends character streams: a directed table of lines, then random lines and noise.
// Each result is checked against a cycle-free parser model. Depends on stcp_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stcp_pkg::*;

  localparam int    RandChars   = 1400;    // characters in the random part
  localparam int    HoldCycles  = 400;     // long result-side hold-off
  localparam int    CycleLimit  = 200000;  // watchdog, far above a normal run
  localparam int    DrainCycles = 10;      // extra wait after the last owed result is taken
  // digit columns are marked by '0'; everything else must match exactly
  localparam string LineTemplate = "SET 00:00:00 00/00/0000";

  localparam result_t FormatErr = '{status: StatusFormat, default: '0};
  localparam result_t RangeErr  = '{status: StatusRange, default: '0};

  typedef struct {
    string   text;
    bit      typed;  // result below is given, not predicted
    result_t want;
  } line_case_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] char_in   = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] status;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  logic [4:0] day_of_month;
  logic [3:0] month;
  logic [6:0] year_two_digit;

  // parser model state, mirrors the block after each accepted character
  logic [4:0] line_col   = '0;
  logic       line_bad   = 1'b0;
  logic [3:0] tens_val   = '0;
  logic [6:0] hour_val   = '0;
  logic [6:0] minute_val = '0;
  logic [6:0] second_val = '0;
  logic [6:0] date_val   = '0;
  logic [6:0] month_val  = '0;
  logic [6:0] year_val   = '0;

  result_t     expected_lines[$];  // results owed by the block, oldest first
  result_t     owed;
  int unsigned errors      = 0;
  int unsigned chars_sent  = 0;
  int unsigned n_ok        = 0;
  int unsigned n_fmt       = 0;
  int unsigned n_range     = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 33;
  int unsigned rx_idle_pct = 33;
  bit          hold_req    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  set_time_command_parser_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_in        (char_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .hour           (hour),
    .minute         (minute),
    .second         (second),
    .day_of_month   (day_of_month),
    .month          (month),
    .year_two_digit (year_two_digit)
  );

  function automatic void clear_line();
    line_col   = '0;
    line_bad   = 1'b0;
    tens_val   = '0;
    hour_val   = '0;
    minute_val = '0;
    second_val = '0;
    date_val   = '0;
    month_val  = '0;
    year_val   = '0;
  endfunction

  // Advance the model by one character; returns 1 when the character ends a line.
  function automatic bit parse_char(input logic [7:0] c, output result_t r);
    logic [4:0] col;
    logic [3:0] d;
    logic [6:0] v;
    bit         is_num;
    r   = '0;
    col = (line_col > LastCol) ? LastCol : line_col;
    // CR/LF ends the line early at any column, even column 0
    if (c == ChCr || c == ChLf) begin
      r.status = StatusFormat;
      clear_line();
      return 1'b1;
    end
    is_num = (c >= ChZero && c <= ChNine);
    d      = is_num ? 4'(c - ChZero) : 4'd0;
    if (LineTemplate[col] != ChZero) begin
      if (c != LineTemplate[col]) line_bad = 1'b1;
    end else begin
      if (!is_num) line_bad = 1'b1;
      // tens column: first digit of a pair; col 21 starts the last year pair
      if (col == 5'd21 || LineTemplate[col - 5'd1] != ChZero) begin
        tens_val = d;
      end else begin
        v = 7'(tens_val * 10 + d);
        case (col)
          5'd5:  hour_val   = v;
          5'd8:  minute_val = v;
          5'd11: second_val = v;
          5'd14: date_val   = v;
          5'd17: month_val  = v;
          5'd22: year_val   = v;
          default: ;  // col 20: century digits are only checked for being digits
        endcase
      end
    end
    if (col != LastCol) begin
      line_col = col + 5'd1;
      return 1'b0;
    end
    if (line_bad) begin
      r.status = StatusFormat;
    end else if (hour_val > MaxHour || minute_val > MaxMinSec || second_val > MaxMinSec ||
                 date_val == 7'd0 || date_val > MaxDate ||
                 month_val == 7'd0 || month_val > MaxMonth) begin
      r.status = StatusRange;
    end else begin
      r.status         = StatusOk;
      r.hour           = hour_val[4:0];
      r.minute         = minute_val[5:0];
      r.second         = second_val[5:0];
      r.day_of_month   = date_val[4:0];
      r.month          = month_val[3:0];
      r.year_two_digit = year_val;
    end
    clear_line();
    return 1'b1;
  endfunction

  function automatic result_t ok_line(input int unsigned h, mi, s, d, mo, y);
    return '{status: StatusOk, hour: 5'(h), minute: 6'(mi), second: 6'(s),
             day_of_month: 5'(d), month: 4'(mo), year_two_digit: 7'(y)};
  endfunction

  // mostly a legal field value, sometimes any two-digit number
  function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
    return ($urandom_range(99) < 85) ? $urandom_range(hi, lo) : $urandom_range(99);
  endfunction

  // One input transaction. Valid only drops when an idle cycle is inserted, so
  // back-to-back characters keep it high across the edge.
  task automatic send_char(input logic [7:0] c, input bit typed = 1'b0,
                           input result_t want = '0);
    result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
    if (parse_char(c, r)) expected_lines.push_back(typed ? want : r);
  endtask

  task automatic check_field(input string name, input int unsigned want_v, got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // Result side: random ready, plus one long hold-off on request. The hold-off
  // is counted here so the sender keeps pushing and the block backs up.
  initial begin : result_side
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (int k = 0; k < HoldCycles; k++) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Every accepted result transaction is matched to the oldest owed line.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_lines.size() == 0) begin
        $display("%0t: result with nothing owed, status %0d", $time, status);
        errors++;
      end else begin
        owed = expected_lines.pop_front();
        check_field("status", owed.status, status);
        check_field("hour", owed.hour, hour);
        check_field("minute", owed.minute, minute);
        check_field("second", owed.second, second);
        check_field("day_of_month", owed.day_of_month, day_of_month);
        check_field("month", owed.month, month);
        check_field("year_two_digit", owed.year_two_digit, year_two_digit);
      end
      if (status == StatusOk) n_ok++;
      else if (status == StatusFormat) n_fmt++;
      else n_range++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d results still owed", $time, expected_lines.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    line_case_t  dir_rows[$];
    string       txt;
    int          bad_col;
    int          cut;
    int unsigned first_rand;
    int unsigned n;
    int unsigned kind;
    bit          held;
    held = 1'b0;
    // directed lines; typed rows carry a result read straight off the format
    dir_rows = '{
      '{"\015", 1'b1, FormatErr},                          // CR at column 0
      '{"\012", 1'b1, FormatErr},                          // LF at column 0
      '{"SET 23:59:59 31/12/2099", 1'b1, ok_line(23, 59, 59, 31, 12, 99)},
      '{"SET 00:00:00 01/01/0000", 1'b1, ok_line(0, 0, 0, 1, 1, 0)},
      '{"SET 12:34:56 31/02/2024", 1'b1, ok_line(12, 34, 56, 31, 2, 24)},  // no date/month check
      '{"SET 24:00:00 01/01/2000", 1'b1, RangeErr},
      '{"SET 00:60:00 01/01/2000", 1'b1, RangeErr},
      '{"SET 00:00:60 01/01/2000", 1'b1, RangeErr},
      '{"SET 00:00:00 00/01/2000", 1'b1, RangeErr},
      '{"SET 00:00:00 32/01/2000", 1'b1, RangeErr},
      '{"SET 00:00:00 01/00/2000", 1'b1, RangeErr},
      '{"SET 00:00:00 01/13/2000", 1'b1, RangeErr},
      '{"SET 99:99:99 99/99/9999", 1'b1, RangeErr},
      '{"SET 12:3\015", 1'b1, FormatErr},                  // early CR mid-line
      '{"set 12:30:00 15/06/2024", 1'b1, FormatErr},
      '{"SETX12:30:00 15/06/2024", 1'b1, FormatErr},
      '{"SET 12-30:00 15/06/2024", 1'b1, FormatErr},
      '{"SET 1A:30:00 15/06/2024", 1'b1, FormatErr},
      '{"SET 12:30:00 15/06/AB24", 1'b1, FormatErr},       // century must still be digits
      '{"SET 12:30:00 15/06/19x4", 1'b1, FormatErr},
      '{"SET 07:05:09 28/02/1999", 1'b0, '0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].text.len(); k++)
        send_char(dir_rows[i].text[k], dir_rows[i].typed && k == dir_rows[i].text.len() - 1,
                  dir_rows[i].want);
    end

    // Random part: mostly well-formed lines with random values, some with one
    // corrupted column, some cut short by CR/LF, the rest raw noise.
    first_rand = chars_sent;
    while (chars_sent - first_rand < RandChars) begin
      n = chars_sent - first_rand;
      // a stretch with back-to-back transactions on both sides
      tx_idle_pct = (n >= 500 && n < 900) ? 0 : 33;
      rx_idle_pct = tx_idle_pct;
      if (!held && n >= 1200) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 80) begin
        // noise may have left the parser mid-line; a line end realigns it
        if (line_col != 0) send_char($urandom_range(1) ? ChCr : ChLf);
        txt = $sformatf("SET %02d:%02d:%02d %02d/%02d/%04d", pick(0, 23), pick(0, 59),
                        pick(0, 59), pick(1, 31), pick(1, 12), $urandom_range(9999));
        bad_col = (kind >= 65 && kind < 72) ? int'($urandom_range(22)) : -1;
        cut     = (kind >= 72) ? int'($urandom_range(22)) : 23;
        for (int k = 0; k < cut; k++)
          send_char((k == bad_col) ? 8'($urandom_range(255)) : txt[k]);
        if (cut < 23) send_char($urandom_range(1) ? ChCr : ChLf);
      end else begin
        repeat ($urandom_range(8, 1)) send_char(8'($urandom_range(255)));
      end
    end
    in_valid <= 1'b0;
    tx_idle_pct = 33;
    rx_idle_pct = 33;

    while (expected_lines.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Summary: %0d characters sent, with a back-to-back stretch and a long stall",
             chars_sent);
    $display("Summary: lines checked: %0d ok, %0d format error, %0d out of range",
             n_ok, n_fmt, n_range);
    if (errors == 0 && expected_lines.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
